FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the mwf_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define MWF_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset
`define MWF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: sv/mwf_pkg.sv
// ----------------------------------------------------------------------------
// mwf_pkg
// Types, codes and helpers for the right-hand wall follower.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwf_pkg;

  // Field widths
  localparam int X_W        = 7;
  localparam int Y_W        = 5;
  localparam int HDG_W      = 2;
  localparam int STS_W      = 3;
  localparam int ACT_W      = 2;
  localparam int MW_W       = 8;
  localparam int MH_W       = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Largest maze the coordinate fields can address
  localparam int FIELD_X_LIMIT = 128;
  localparam int FIELD_Y_LIMIT = 32;

  // Actions
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STEP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

  // Headings
  localparam logic [HDG_W-1:0] HDG_SOUTH = 2'd0;
  localparam logic [HDG_W-1:0] HDG_NORTH = 2'd1;
  localparam logic [HDG_W-1:0] HDG_WEST  = 2'd2;
  localparam logic [HDG_W-1:0] HDG_EAST  = 2'd3;

  // Result status
  localparam logic [STS_W-1:0] STS_WRITTEN     = 3'd0;
  localparam logic [STS_W-1:0] STS_TURNED_LEFT = 3'd1;
  localparam logic [STS_W-1:0] STS_MOVED       = 3'd2;
  localparam logic [STS_W-1:0] STS_EXITED      = 3'd3;
  localparam logic [STS_W-1:0] STS_START_WALL  = 3'd4;
  localparam logic [STS_W-1:0] STS_IGNORED     = 3'd5;
  localparam logic [STS_W-1:0] STS_RESTARTED   = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAZE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAZE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd4;

  // Input beat
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [X_W-1:0]   cell_x;
    logic [Y_W-1:0]   cell_y;
    logic             cell_is_wall;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [X_W-1:0]   pos_x;
    logic [Y_W-1:0]   pos_y;
    logic [HDG_W-1:0] heading;
    logic [STS_W-1:0] status;
  } out_item_t;

  // Outcome of one cell probe
  typedef struct packed {
    logic           in_bounds;
    logic           border;
    logic [X_W-1:0] nx;
    logic [Y_W-1:0] ny;
  } probe_t;

  function automatic logic [HDG_W-1:0] turn_right(input logic [HDG_W-1:0] h);
    logic [HDG_W-1:0] r;
    unique case (h)
      HDG_SOUTH: r = HDG_WEST;
      HDG_NORTH: r = HDG_EAST;
      HDG_WEST:  r = HDG_NORTH;
      default:   r = HDG_SOUTH;
    endcase
    return r;
  endfunction

  function automatic logic [HDG_W-1:0] turn_left(input logic [HDG_W-1:0] h);
    logic [HDG_W-1:0] r;
    unique case (h)
      HDG_SOUTH: r = HDG_EAST;
      HDG_NORTH: r = HDG_WEST;
      HDG_WEST:  r = HDG_SOUTH;
      default:   r = HDG_NORTH;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/mwf_ram.sv
// ----------------------------------------------------------------------------
// mwf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mwf_cell_unit.sv
// ----------------------------------------------------------------------------
// mwf_cell_unit
// Shared probe unit: neighbour coordinates, bounds, border and map address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwf_cell_unit import mwf_pkg::*; #(
  parameter int EFF_W = 128,
  parameter int EFF_H = 32
) (
  input  logic [X_W-1:0]                   x,
  input  logic [Y_W-1:0]                   y,
  input  logic [HDG_W-1:0]                 dir,
  input  logic                             stay,
  input  logic [MW_W-1:0]                  lim_w,
  input  logic [MH_W-1:0]                  lim_h,
  output logic [$clog2(EFF_W*EFF_H)-1:0]   addr,
  output probe_t                           probe
);

  localparam int AW = $clog2(EFF_W*EFF_H);

  logic [MW_W-1:0] dx;
  logic [MH_W-1:0] dy;
  logic [MW_W-1:0] xe;
  logic [MH_W-1:0] ye;

  // Step offset; minus one wraps so it lands beyond any limit
  always_comb begin
    dx = '0;
    dy = '0;
    if (!stay) begin
      unique case (dir)
        HDG_SOUTH: dy = MH_W'(1);
        HDG_NORTH: dy = '1;
        HDG_WEST:  dx = '1;
        default:   dx = MW_W'(1);
      endcase
    end
  end

  assign xe = {1'b0, x} + dx;
  assign ye = {1'b0, y} + dy;

  assign probe.in_bounds = (xe < lim_w) && (ye < lim_h);
  assign probe.border    = (xe == '0) || (ye == '0) ||
                           (xe == lim_w - MW_W'(1)) || (ye == lim_h - MH_W'(1));
  assign probe.nx        = xe[X_W-1:0];
  assign probe.ny        = ye[Y_W-1:0];

  // Row-major address, stride is a constant
  assign addr = AW'(32'(ye) * EFF_W + 32'(xe));

endmodule

FILE: sv/maze_wall_follower_step.sv
// ----------------------------------------------------------------------------
// maze_wall_follower_step
// Right-hand wall follower over a one-bit wall map held in a RAM.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  in      | in        | in_valid / in_stall | in_data   (in_item_t)
//  out     | out       | out_valid/out_stall | out_data  (out_item_t)
//  cfg     | in        | cfg_we              | cfg_addr, cfg_wdata
//
// A cell write, restart or ignored step goes from acceptance straight to the
// result-load state S_OUT. A step passes through S_OWN and S_RIGHT, then
// S_AHEAD and S_DECIDE where needed, before S_OUT: its own, right and
// ahead cells are read one after another through the single map RAM read port.
// One item is in flight at a time; in_stall is high until its result is
// loaded into the output register. A stalled result holds there; the next
// item may be accepted meanwhile and its result waits behind it.
// Reset needs no clearing pass; unwritten map cells read as undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module maze_wall_follower_step import mwf_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int EFF_W = (MAX_WIDTH < FIELD_X_LIMIT) ? MAX_WIDTH : FIELD_X_LIMIT;
  localparam int EFF_H = (MAX_HEIGHT < FIELD_Y_LIMIT) ? MAX_HEIGHT : FIELD_Y_LIMIT;
  localparam int DEPTH = EFF_W * EFF_H;
  localparam int AW    = $clog2(DEPTH);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_OWN    = 3'd1;
  localparam logic [2:0] S_RIGHT  = 3'd2;
  localparam logic [2:0] S_AHEAD  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [X_W-1:0]   walk_x_r, walk_x_nxt;
  logic [Y_W-1:0]   walk_y_r, walk_y_nxt;
  logic [HDG_W-1:0] walk_hdg_r, walk_hdg_nxt;
  logic             finished_r, finished_nxt;
  logic [STS_W-1:0] status_r, status_nxt;
  logic             oob_r, oob_nxt;
  logic [X_W-1:0]   cand_x_r, cand_x_nxt;
  logic [Y_W-1:0]   cand_y_r, cand_y_nxt;
  logic             cand_border_r, cand_border_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [MW_W-1:0]  maze_w_r;
  logic [MH_W-1:0]  maze_h_r;
  logic [X_W-1:0]   start_x_r;
  logic [Y_W-1:0]   start_y_r;
  logic [HDG_W-1:0] start_hdg_r;

  logic [MW_W-1:0]  used_w;
  logic [MH_W-1:0]  used_h;
  logic             in_acc;
  logic             cell_wall;

  // Probe unit inputs and outputs
  logic [X_W-1:0]   pu_x;
  logic [Y_W-1:0]   pu_y;
  logic [HDG_W-1:0] pu_dir;
  logic             pu_stay;
  logic [MW_W-1:0]  pu_lim_w;
  logic [MH_W-1:0]  pu_lim_h;
  logic [AW-1:0]    pu_addr;
  probe_t           pu_probe;

  logic             ram_we;
  logic             ram_rdata;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Maze size actually in use
  assign used_w = (maze_w_r < MW_W'(EFF_W)) ? maze_w_r : MW_W'(EFF_W);
  assign used_h = (maze_h_r < MH_W'(EFF_H)) ? maze_h_r : MH_W'(EFF_H);

  // Cell from the previous probe is a wall if off the map or marked
  assign cell_wall = oob_r || ram_rdata;

  // Probe selection per state
  always_comb begin
    pu_x     = walk_x_r;
    pu_y     = walk_y_r;
    pu_dir   = walk_hdg_r;
    pu_stay  = 1'b0;
    pu_lim_w = used_w;
    pu_lim_h = used_h;
    unique case (state_r)
      S_IDLE: begin
        pu_x     = in_data.cell_x;
        pu_y     = in_data.cell_y;
        pu_stay  = 1'b1;
        pu_lim_w = MW_W'(EFF_W);
        pu_lim_h = MH_W'(EFF_H);
      end
      S_OWN:   pu_stay = 1'b1;
      S_RIGHT: pu_dir  = turn_right(walk_hdg_r);
      default: pu_dir  = walk_hdg_r;
    endcase
  end

  mwf_cell_unit #(
    .EFF_W (EFF_W),
    .EFF_H (EFF_H)
  ) u_cell (
    .x     (pu_x),
    .y     (pu_y),
    .dir   (pu_dir),
    .stay  (pu_stay),
    .lim_w (pu_lim_w),
    .lim_h (pu_lim_h),
    .addr  (pu_addr),
    .probe (pu_probe)
  );

  assign ram_we = in_acc && (in_data.action == ACT_WRITE) && pu_probe.in_bounds;

  mwf_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pu_addr),
    .wdata (in_data.cell_is_wall),
    .raddr (pu_addr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    walk_x_nxt      = walk_x_r;
    walk_y_nxt      = walk_y_r;
    walk_hdg_nxt    = walk_hdg_r;
    finished_nxt    = finished_r;
    status_nxt      = status_r;
    oob_nxt         = oob_r;
    cand_x_nxt      = cand_x_r;
    cand_y_nxt      = cand_y_r;
    cand_border_nxt = cand_border_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_data.action == ACT_WRITE) begin
            status_nxt = STS_WRITTEN;
            state_nxt  = S_OUT;
          end else if (in_data.action == ACT_RESTART) begin
            walk_x_nxt   = start_x_r;
            walk_y_nxt   = start_y_r;
            walk_hdg_nxt = start_hdg_r;
            finished_nxt = 1'b0;
            status_nxt   = STS_RESTARTED;
            state_nxt    = S_OUT;
          end else if (in_data.action == ACT_STEP && !finished_r) begin
            state_nxt = S_OWN;
          end else begin
            status_nxt = STS_IGNORED;
            state_nxt  = S_OUT;
          end
        end
      end

      // read own cell
      S_OWN: begin
        oob_nxt   = !pu_probe.in_bounds;
        state_nxt = S_RIGHT;
      end

      // own cell arrives; read right cell
      S_RIGHT: begin
        if (cell_wall) begin
          finished_nxt = 1'b1;
          status_nxt   = STS_START_WALL;
          state_nxt    = S_OUT;
        end else begin
          oob_nxt         = !pu_probe.in_bounds;
          cand_x_nxt      = pu_probe.nx;
          cand_y_nxt      = pu_probe.ny;
          cand_border_nxt = pu_probe.border;
          state_nxt       = S_AHEAD;
        end
      end

      // right cell arrives; read cell ahead
      S_AHEAD: begin
        if (!cell_wall) begin
          walk_hdg_nxt = turn_right(walk_hdg_r);
          walk_x_nxt   = cand_x_r;
          walk_y_nxt   = cand_y_r;
          finished_nxt = cand_border_r;
          status_nxt   = cand_border_r ? STS_EXITED : STS_MOVED;
          state_nxt    = S_OUT;
        end else begin
          oob_nxt         = !pu_probe.in_bounds;
          cand_x_nxt      = pu_probe.nx;
          cand_y_nxt      = pu_probe.ny;
          cand_border_nxt = pu_probe.border;
          state_nxt       = S_DECIDE;
        end
      end

      // cell ahead arrives
      S_DECIDE: begin
        if (cell_wall) begin
          walk_hdg_nxt = turn_left(walk_hdg_r);
          status_nxt   = STS_TURNED_LEFT;
        end else begin
          walk_x_nxt   = cand_x_r;
          walk_y_nxt   = cand_y_r;
          finished_nxt = cand_border_r;
          status_nxt   = cand_border_r ? STS_EXITED : STS_MOVED;
        end
        state_nxt = S_OUT;
      end

      // load result once the output register is free
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.pos_x   = walk_x_r;
          out_data_nxt.pos_y   = walk_y_r;
          out_data_nxt.heading = walk_hdg_r;
          out_data_nxt.status  = status_r;
          state_nxt            = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and walker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_x_r    <= '0;
      walk_y_r    <= '0;
      walk_hdg_r  <= HDG_NORTH;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_x_r    <= walk_x_nxt;
      walk_y_r    <= walk_y_nxt;
      walk_hdg_r  <= walk_hdg_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    status_r      <= status_nxt;
    oob_r         <= oob_nxt;
    cand_x_r      <= cand_x_nxt;
    cand_y_r      <= cand_y_nxt;
    cand_border_r <= cand_border_nxt;
    out_data_r    <= out_data_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maze_w_r    <= MW_W'(FIELD_X_LIMIT);
      maze_h_r    <= MH_W'(FIELD_Y_LIMIT);
      start_x_r   <= '0;
      start_y_r   <= '0;
      start_hdg_r <= HDG_NORTH;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAZE_WIDTH:    maze_w_r    <= cfg_wdata[MW_W-1:0];
        REG_MAZE_HEIGHT:   maze_h_r    <= cfg_wdata[MH_W-1:0];
        REG_START_X:       start_x_r   <= cfg_wdata[X_W-1:0];
        REG_START_Y:       start_y_r   <= cfg_wdata[Y_W-1:0];
        REG_START_HEADING: start_hdg_r <= cfg_wdata[HDG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/mwf_checker.sv
// ----------------------------------------------------------------------------
// mwf_checker
// Port-level checks for the wall follower, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwf_checker import mwf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input in_item_t              in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_item_t             out_data,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_addr,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // a stalled result beat stays offered and unchanged
  `MWF_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped under stall")
  `MWF_ASSERT_CLK(a_out_stable, out_valid && out_stall |=> $stable(out_data), "stalled result changed")

  // one item at a time: busy right after an input beat is taken
  `MWF_ASSERT_CLK(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second item taken while busy")

  // a new result only appears at the end of a busy spell
  `MWF_ASSERT_CLK(a_result_after_work, $rose(out_valid) |-> $past(in_stall), "result without work")

  // reset empties the output register
  `MWF_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind maze_wall_follower_step mwf_checker u_mwf_checker (.*);
